### sv/spads_pkg.sv
// Package for the sorted pair distance sum block: widths and sizes.
// Used by the top level.
package spads_pkg;
  localparam int MaxPairs = 1024;
  localparam int AddrW    = $clog2(MaxPairs);
  localparam int CountW   = $clog2(MaxPairs + 1);
  localparam int ValW     = 20;
  localparam int SumW     = 32;
  typedef logic [ValW-1:0]   val_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [SumW-1:0]   sum_t;
endpackage

### sv/spads_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module spads_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/sorted_pair_abs_distance_sum_top.sv
// Sorted pair distance sum: insertion sort of two lists in RAM, then sum of |l-r|.
// Insert into the held pairs: a read and a compare per shifted entry, both lists in
// parallel, while busy; a dropped non-last item is discarded and the block stays idle.
// On a last item a summing pass over the held pairs follows; the result strobes at its
// end and cannot be stalled. Reset (synchronous, active low) empties the
// lists; RAM contents are never cleared. Depends on spads_pkg and spads_ram.
module sorted_pair_abs_distance_sum_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [19:0]            in_left_value,
  input  logic [19:0]            in_right_value,
  input  logic                   in_last_pair,
  output logic                   out_valid,
  output logic [31:0]            out_distance_sum,
  output logic                   out_overflowed,
  output logic                   out_saturated
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StCmp  = 3'd2;
  localparam logic [2:0] StSumR = 3'd3;
  localparam logic [2:0] StSumA = 3'd4;

  logic [2:0] state_r, state_nxt;
  spads_pkg::count_t count_r, count_nxt;
  spads_pkg::count_t pos_r, pos_nxt;
  logic drop_r, drop_nxt;
  logic last_r, last_nxt;
  logic ldone_r, ldone_nxt, rdone_r, rdone_nxt;
  spads_pkg::val_t lv_r, rv_r;
  spads_pkg::sum_t sum_r, sum_nxt;
  logic sat_r, sat_nxt;

  logic l_we, r_we;
  spads_pkg::addr_t l_wa, r_wa, rd_a;
  spads_pkg::val_t l_wd, r_wd, l_rd, r_rd;

  spads_ram #(.Width(spads_pkg::ValW), .Depth(spads_pkg::MaxPairs)) u_left (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(rd_a), .rdata(l_rd));
  spads_ram #(.Width(spads_pkg::ValW), .Depth(spads_pkg::MaxPairs)) u_right (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(rd_a), .rdata(r_rd));

  logic accept;
  logic [spads_pkg::ValW:0] diff;
  logic [spads_pkg::SumW:0] sum_wide;
  spads_pkg::count_t pos_m1;

  assign accept = start && !busy;
  assign busy   = (state_r != StIdle);
  assign pos_m1 = pos_r - spads_pkg::CountW'(1);
  assign diff = (l_rd >= r_rd) ? {1'b0, l_rd - r_rd} : {1'b0, r_rd - l_rd};
  assign sum_wide = {1'b0, sum_r} + (spads_pkg::SumW + 1)'(diff);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    drop_nxt  = drop_r;
    last_nxt  = last_r;
    ldone_nxt = ldone_r;
    rdone_nxt = rdone_r;
    sum_nxt   = sum_r;
    sat_nxt   = sat_r;
    l_we = 1'b0; r_we = 1'b0;
    l_wa = pos_r[spads_pkg::AddrW-1:0];
    r_wa = pos_r[spads_pkg::AddrW-1:0];
    l_wd = lv_r; r_wd = rv_r;
    rd_a = pos_m1[spads_pkg::AddrW-1:0];
    out_valid = 1'b0;
    unique case (state_r)
      StIdle: begin
        if (accept) begin
          last_nxt = in_last_pair;
          pos_nxt  = count_r;
          ldone_nxt = 1'b0;
          rdone_nxt = 1'b0;
          if (count_r == spads_pkg::CountW'(spads_pkg::MaxPairs)) begin
            drop_nxt = 1'b1;
            pos_nxt  = '0;
            sum_nxt  = '0;
            sat_nxt  = 1'b0;
            state_nxt = in_last_pair ? StSumR : StIdle;
          end else begin
            state_nxt = StRead;
          end
        end
      end
      StRead: begin
        // issue read of entry pos-1 (or finish at position 0)
        if (pos_r == '0) begin
          l_we = !ldone_r; r_we = !rdone_r;
          count_nxt = count_r + spads_pkg::CountW'(1);
          pos_nxt = '0; sum_nxt = '0; sat_nxt = 1'b0;
          state_nxt = last_r ? StSumR : StIdle;
        end else begin
          state_nxt = StCmp;
        end
      end
      StCmp: begin
        // shift larger entries up one place; drop the value in where it stops
        if (!ldone_r) begin
          l_we = 1'b1;
          if (l_rd > lv_r) l_wd = l_rd; else ldone_nxt = 1'b1;
        end
        if (!rdone_r) begin
          r_we = 1'b1;
          if (r_rd > rv_r) r_wd = r_rd; else rdone_nxt = 1'b1;
        end
        if ((ldone_r || !(l_rd > lv_r)) && (rdone_r || !(r_rd > rv_r))) begin
          count_nxt = count_r + spads_pkg::CountW'(1);
          pos_nxt = '0; sum_nxt = '0; sat_nxt = 1'b0;
          state_nxt = last_r ? StSumR : StIdle;
        end else begin
          pos_nxt = pos_m1;
          state_nxt = StRead;
        end
      end
      StSumR: begin
        rd_a = pos_r[spads_pkg::AddrW-1:0];
        if (pos_r == count_r) begin
          out_valid = 1'b1;
          count_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = StIdle;
        end else begin
          state_nxt = StSumA;
        end
      end
      StSumA: begin
        if (sum_wide[spads_pkg::SumW]) begin
          sum_nxt = '1; sat_nxt = 1'b1;
        end else begin
          sum_nxt = sum_wide[spads_pkg::SumW-1:0];
        end
        pos_nxt = pos_r + spads_pkg::CountW'(1);
        state_nxt = StSumR;
      end
      default: state_nxt = StIdle;
    endcase
  end

  assign out_distance_sum = sum_r;
  assign out_overflowed   = drop_r;
  assign out_saturated    = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      count_r <= '0;
      pos_r   <= '0;
      drop_r  <= 1'b0;
      last_r  <= 1'b0;
      ldone_r <= 1'b0;
      rdone_r <= 1'b0;
      sat_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      drop_r  <= drop_nxt;
      last_r  <= last_nxt;
      ldone_r <= ldone_nxt;
      rdone_r <= rdone_nxt;
      sat_r   <= sat_nxt;
    end
    sum_r <= sum_nxt;
    if (accept) begin
      lv_r <= in_left_value;
      rv_r <= in_right_value;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spads_pkg::CountW'(spads_pkg::MaxPairs))
    else $error("pair count above capacity");
  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (count_r == '0) && !drop_r && (state_r == StIdle))
    else $error("store not emptied after result");
  a_result_only_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == StSumR)
    else $error("result strobe outside sum pass");
`endif
endmodule
